// ===== rtl/i2cmrt_pkg.sv =====
package i2cmrt_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] wr_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       data_request;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       done_res;
    logic       error;
  } out_t;

  localparam int CFG_W = 10;

  localparam logic [0:0] CFG_ACK_TIMEOUT = 1'd0;
  localparam logic [0:0] CFG_HALF_PERIOD = 1'd1;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [9:0] HALF_PERIOD_RST = 10'd1;

  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // transaction progress
  localparam logic [2:0] STG_ADDR  = 3'd0;
  localparam logic [2:0] STG_REG   = 3'd1;
  localparam logic [2:0] STG_DATA  = 3'd2;
  localparam logic [2:0] STG_RADDR = 3'd3;
  localparam logic [2:0] STG_ABORT = 3'd7;

  typedef enum logic [17:0] {
    PH_IDLE      = 18'b000000000000000001,
    PH_START_A   = 18'b000000000000000010,
    PH_START_B   = 18'b000000000000000100,
    PH_START_C   = 18'b000000000000001000,
    PH_TX_LOW    = 18'b000000000000010000,
    PH_TX_HIGH   = 18'b000000000000100000,
    PH_ACK_LOW   = 18'b000000000001000000,
    PH_ACK_HIGH  = 18'b000000000010000000,
    PH_FETCH     = 18'b000000000100000000,
    PH_RS_A      = 18'b000000001000000000,
    PH_RS_B      = 18'b000000010000000000,
    PH_RX_LOW    = 18'b000000100000000000,
    PH_RX_HIGH   = 18'b000001000000000000,
    PH_MACK_LOW  = 18'b000010000000000000,
    PH_MACK_HIGH = 18'b000100000000000000,
    PH_STOP_A    = 18'b001000000000000000,
    PH_STOP_B    = 18'b010000000000000000,
    PH_STOP_C    = 18'b100000000000000000
  } phase_t;

endpackage

// ===== rtl/i2c_master_register_transfer.sv =====
// I2C master for register write and read transactions, one bus tick per item.
// The result for a tick is registered and presented in the cycle after it is accepted.
// Throughput: one tick per cycle; the bus sequencer and its output register
// advance together, so in_ready only drops while a result is held by out_ready.
// Reset (synchronous, active low): sequencer idle, counters cleared,
// ack_timeout = 250, half_period_ticks = 1, no result pending.
module i2c_master_register_transfer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  i2cmrt_pkg::in_t          in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output i2cmrt_pkg::out_t         out_data,
  input  logic                     cfg_wr_en,
  input  logic [0:0]               cfg_index,
  input  logic [i2cmrt_pkg::CFG_W-1:0] cfg_wdata
);
  import i2cmrt_pkg::*;

  logic [7:0] ack_timeout_r;
  logic [9:0] half_period_r;

  phase_t     phase_r, phase_nxt, phase_c;
  logic [2:0] stage_r, stage_nxt, stage_c;
  logic [2:0] bits_r, bits_nxt, bits_c;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt, left_c;
  logic [7:0] wait_r, wait_nxt, wait_c;
  logic [9:0] tick_r, tick_nxt, tick_c;
  logic [6:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic       is_read_r, is_read_nxt;

  out_t       res;
  out_t       out_r;
  logic       out_valid_r;
  logic       accept;

  logic [9:0]  half_eff;
  logic [10:0] tick_inc;
  logic        seg_over;
  logic [2:0]  bits_inc;
  logic [7:0]  wait_inc;
  logic [7:0]  rx_shift;
  logic        cmd;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // command overlay: a start command while idle loads the transaction
  assign cmd = (phase_r == PH_IDLE) &&
               (in_data.func == FUNC_WRITE || in_data.func == FUNC_READ);

  always_comb begin
    phase_c = phase_r;
    stage_c = stage_r;
    bits_c  = bits_r;
    left_c  = left_r;
    wait_c  = wait_r;
    tick_c  = tick_r;
    if (cmd) begin
      phase_c = PH_START_A;
      stage_c = STG_ADDR;
      bits_c  = 3'd0;
      left_c  = in_data.length;
      wait_c  = 8'd0;
      tick_c  = 10'd0;
    end
  end

  assign half_eff = (half_period_r == 10'd0) ? 10'd1 : half_period_r;
  assign tick_inc = {1'b0, tick_c} + 11'd1;
  assign seg_over = tick_inc >= {1'b0, half_eff};
  assign bits_inc = bits_c + 3'd1;
  assign wait_inc = wait_c + 8'd1;
  assign rx_shift = {shift_r[6:0], in_data.sda_in};

  always_comb begin
    phase_nxt   = phase_c;
    stage_nxt   = stage_c;
    bits_nxt    = bits_c;
    shift_nxt   = shift_r;
    left_nxt    = left_c;
    wait_nxt    = wait_c;
    tick_nxt    = seg_over ? 10'd0 : tick_inc[9:0];
    dev_nxt     = cmd ? in_data.dev_addr : dev_r;
    reg_nxt     = cmd ? in_data.reg_addr : reg_r;
    is_read_nxt = cmd ? (in_data.func == FUNC_READ) : is_read_r;

    res              = '0;
    res.scl          = 1'b1;
    res.sda_out      = 1'b1;
    res.busy_res     = 1'b1;

    case (phase_c)
      PH_START_A: begin
        res.sda_drive = 1'b1;
        if (seg_over) phase_nxt = PH_START_B;
      end
      PH_START_B: begin
        res.sda_drive = 1'b1;
        res.sda_out   = 1'b0;
        if (seg_over) phase_nxt = PH_START_C;
      end
      PH_START_C: begin
        res.sda_drive = 1'b1;
        res.sda_out   = 1'b0;
        res.scl       = 1'b0;
        if (seg_over) begin
          shift_nxt = {dev_nxt, stage_c == STG_RADDR};
          bits_nxt  = 3'd0;
          phase_nxt = PH_TX_LOW;
        end
      end
      PH_TX_LOW, PH_TX_HIGH: begin
        res.sda_drive = 1'b1;
        res.sda_out   = shift_r[7];
        res.scl       = (phase_c == PH_TX_HIGH);
        if (seg_over) begin
          if (phase_c == PH_TX_LOW) begin
            phase_nxt = PH_TX_HIGH;
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bits_nxt  = bits_inc;
            phase_nxt = (bits_inc == 3'd0) ? PH_ACK_LOW : PH_TX_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        res.scl = 1'b0;
        if (seg_over) begin
          wait_nxt  = 8'd0;
          phase_nxt = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        // this slot ignores the segment timer; it ends on ack or timeout
        tick_nxt = tick_c;
        if (!in_data.sda_in) begin
          tick_nxt = 10'd0;
          if (stage_c == STG_ADDR) begin
            stage_nxt = STG_REG;
            shift_nxt = reg_r;
            bits_nxt  = 3'd0;
            phase_nxt = PH_TX_LOW;
          end else if (stage_c == STG_REG && is_read_r) begin
            stage_nxt = STG_RADDR;
            phase_nxt = PH_RS_A;
          end else if (stage_c == STG_RADDR) begin
            bits_nxt  = 3'd0;
            shift_nxt = 8'd0;
            phase_nxt = (left_c != 8'd0) ? PH_RX_LOW : PH_STOP_A;
          end else if (left_c != 8'd0) begin
            res.data_request = 1'b1;
            phase_nxt        = PH_FETCH;
          end else begin
            phase_nxt = PH_STOP_A;
          end
        end else begin
          wait_nxt = wait_inc;
          if (wait_inc >= ack_timeout_r) begin
            stage_nxt = STG_ABORT;
            tick_nxt  = 10'd0;
            phase_nxt = PH_STOP_A;
          end
        end
      end
      PH_FETCH: begin
        res.scl   = 1'b0;
        stage_nxt = STG_DATA;
        left_nxt  = left_c - 8'd1;
        shift_nxt = in_data.wr_data;
        bits_nxt  = 3'd0;
        tick_nxt  = 10'd0;
        phase_nxt = PH_TX_LOW;
      end
      PH_RS_A, PH_RS_B: begin
        res.sda_drive = 1'b1;
        res.scl       = (phase_c == PH_RS_B);
        if (seg_over) phase_nxt = (phase_c == PH_RS_A) ? PH_RS_B : PH_START_B;
      end
      PH_RX_LOW: begin
        res.scl = 1'b0;
        if (seg_over) phase_nxt = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        if (seg_over) begin
          shift_nxt = rx_shift;
          bits_nxt  = bits_inc;
          if (bits_inc == 3'd0) begin
            res.rd_valid = 1'b1;
            res.rd_data  = rx_shift;
            res.rd_last  = (left_c == 8'd1);
            left_nxt     = left_c - 8'd1;
            phase_nxt    = PH_MACK_LOW;
          end else begin
            phase_nxt = PH_RX_LOW;
          end
        end
      end
      PH_MACK_LOW, PH_MACK_HIGH: begin
        // NACK on the last byte
        res.sda_drive = 1'b1;
        res.sda_out   = (left_c == 8'd0);
        res.scl       = (phase_c == PH_MACK_HIGH);
        if (seg_over) begin
          if (phase_c == PH_MACK_LOW) begin
            phase_nxt = PH_MACK_HIGH;
          end else begin
            shift_nxt = 8'd0;
            phase_nxt = (left_c != 8'd0) ? PH_RX_LOW : PH_STOP_A;
          end
        end
      end
      PH_STOP_A: begin
        res.sda_drive = 1'b1;
        res.sda_out   = 1'b0;
        res.scl       = 1'b0;
        if (seg_over) phase_nxt = PH_STOP_B;
      end
      PH_STOP_B: begin
        res.sda_drive = 1'b1;
        res.sda_out   = 1'b0;
        if (seg_over) phase_nxt = PH_STOP_C;
      end
      PH_STOP_C: begin
        res.sda_drive = 1'b1;
        if (seg_over) begin
          res.done_res = 1'b1;
          res.error    = (stage_c == STG_ABORT);
          stage_nxt    = STG_ADDR;
          phase_nxt    = PH_IDLE;
        end
      end
      default: begin
        res.busy_res = 1'b0;
        phase_nxt    = PH_IDLE;
        tick_nxt     = tick_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[7:0];
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      stage_r     <= 3'd0;
      bits_r      <= 3'd0;
      shift_r     <= 8'd0;
      left_r      <= 8'd0;
      wait_r      <= 8'd0;
      tick_r      <= 10'd0;
      dev_r       <= 7'd0;
      reg_r       <= 8'd0;
      is_read_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        stage_r   <= stage_nxt;
        bits_r    <= bits_nxt;
        shift_r   <= shift_nxt;
        left_r    <= left_nxt;
        wait_r    <= wait_nxt;
        tick_r    <= tick_nxt;
        dev_r     <= dev_nxt;
        reg_r     <= reg_nxt;
        is_read_r <= is_read_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

endmodule
